[src/lwm_pkg.sv]
package lwm_pkg;

  // Operation codes carried in the op field of an input word.
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STEP   = 3'd2;
  localparam logic [2:0] OP_FINISH = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Trial step directions.
  localparam logic [1:0] DIR_ROW_DN = 2'd0;
  localparam logic [1:0] DIR_ROW_UP = 2'd1;
  localparam logic [1:0] DIR_COL_DN = 2'd2;
  localparam logic [1:0] DIR_COL_UP = 2'd3;

  // Reset value of the dmax register.
  localparam logic [15:0] DMAX_RESET = 16'hFFFF;

  // Offsets stay within this magnitude so the squared displacement fits 31 bits.
  localparam logic signed [16:0] OFF_LIMIT = 17'sd32767;

  // Queue between front and back; depth must be a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Operation class decided by the front end.
  typedef enum logic [2:0] {
    K_WRITE,
    K_START,
    K_STEP,
    K_FINISH,
    K_CLEAR,
    K_NONE
  } lwm_kind_t;

  // Back end sequencer states.
  typedef enum logic {
    B_IDLE,
    B_LOOKUP
  } lwm_bstate_t;

  // Input word.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [15:0] cell_value;
    logic [1:0]  direction;
    logic [15:0] accept_draw;
  } lwm_in_t;

  // Result word.
  typedef struct packed {
    logic [7:0]  pos_row;
    logic [7:0]  pos_col;
    logic        moved;
    logic [30:0] disp_sq;
    logic [47:0] total_disp_sq;
    logic [31:0] walks_done;
  } lwm_out_t;

  // Classified operation waiting in the queue.
  typedef struct packed {
    lwm_kind_t   kind;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [15:0] cell_value;
    logic [1:0]  direction;
    logic [15:0] thresh;
  } lwm_entry_t;

endpackage

[src/lwm_ram.sv]
module lwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/lwm_front.sv]
module lwm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwm_pkg::lwm_in_t    in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output lwm_pkg::lwm_entry_t q_entry
);

  import lwm_pkg::*;

  logic [15:0] dmax;
  logic [31:0] product;
  lwm_kind_t   kind;

  // The dmax register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dmax <= DMAX_RESET;
    end else if (cfg_valid) begin
      dmax <= cfg_data;
    end
  end

  // A word is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Decode the operation code.
  always_comb begin
    unique case (in_data.op)
      OP_WRITE:  kind = K_WRITE;
      OP_START:  kind = K_START;
      OP_STEP:   kind = K_STEP;
      OP_FINISH: kind = K_FINISH;
      OP_CLEAR:  kind = K_CLEAR;
      default:   kind = K_NONE;
    endcase
  end

  // Acceptance threshold is the draw scaled by dmax, floor of the Q0.16 product.
  assign product = 32'(in_data.accept_draw) * 32'(dmax);

  always_comb begin
    q_entry.kind       = kind;
    q_entry.cell_row   = in_data.cell_row;
    q_entry.cell_col   = in_data.cell_col;
    q_entry.cell_value = in_data.cell_value;
    q_entry.direction  = in_data.direction;
    q_entry.thresh     = product[31:16];
  end

endmodule

[src/lwm_queue.sv]
module lwm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lwm_pkg::lwm_entry_t push_entry,
  output logic                full,
  output logic                valid,
  input  logic                pop,
  output lwm_pkg::lwm_entry_t head
);

  import lwm_pkg::*;

  lwm_entry_t         slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/lwm_back.sv]
module lwm_back #(
  parameter int GRID_BITS  = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  lwm_pkg::lwm_entry_t      q_entry,
  output logic                     q_pop,
  output logic                     ram_we,
  output logic [2*GRID_BITS-1:0]   ram_waddr,
  output logic [VALUE_BITS-1:0]    ram_wdata,
  output logic                     ram_re,
  output logic [2*GRID_BITS-1:0]   ram_raddr,
  input  logic [VALUE_BITS-1:0]    ram_rdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lwm_pkg::lwm_out_t        out_data
);

  import lwm_pkg::*;

  localparam int CMP_W = (VALUE_BITS > 16) ? VALUE_BITS : 16;

  lwm_bstate_t            bstate, bstate_next;
  logic [GRID_BITS-1:0]   start_row, start_row_next;
  logic [GRID_BITS-1:0]   start_col, start_col_next;
  logic signed [15:0]     off_row, off_row_next;
  logic signed [15:0]     off_col, off_col_next;
  logic [30:0]            disp_sq, disp_sq_next;
  logic [47:0]            sum_sq, sum_sq_next;
  logic [31:0]            walk_count, walk_count_next;
  logic signed [15:0]     pend_row, pend_row_next;
  logic signed [15:0]     pend_col, pend_col_next;
  logic signed [17:0]     pend_delta, pend_delta_next;
  logic [15:0]            pend_thresh, pend_thresh_next;
  lwm_out_t               out_data_next;
  logic                   out_valid_next;

  logic                   out_free;
  logic                   load_out;
  logic                   moved;
  logic signed [16:0]     trial_row;
  logic signed [16:0]     trial_col;
  logic signed [17:0]     trial_pair;
  logic                   trial_plus;
  logic                   in_range;
  logic [GRID_BITS-1:0]   look_row;
  logic [GRID_BITS-1:0]   look_col;
  logic signed [31:0]     disp_sum;
  logic [48:0]            sum_ext;
  logic [GRID_BITS-1:0]   pos_row_g;
  logic [GRID_BITS-1:0]   pos_col_g;

  // Control and walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= B_IDLE;
      start_row  <= '0;
      start_col  <= '0;
      off_row    <= '0;
      off_col    <= '0;
      disp_sq    <= '0;
      sum_sq     <= '0;
      walk_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      bstate     <= bstate_next;
      start_row  <= start_row_next;
      start_col  <= start_col_next;
      off_row    <= off_row_next;
      off_col    <= off_col_next;
      disp_sq    <= disp_sq_next;
      sum_sq     <= sum_sq_next;
      walk_count <= walk_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // Pending trial step and result payload.
  always_ff @(posedge clk) begin
    pend_row    <= pend_row_next;
    pend_col    <= pend_col_next;
    pend_delta  <= pend_delta_next;
    pend_thresh <= pend_thresh_next;
    out_data    <= out_data_next;
  end

  // Trial position one cell away from the current offsets.
  always_comb begin
    trial_row  = 17'(off_row);
    trial_col  = 17'(off_col);
    trial_plus = 1'b0;
    case (q_entry.direction)
      DIR_ROW_DN: trial_row = 17'(off_row) - 17'sd1;
      DIR_ROW_UP: begin
        trial_row  = 17'(off_row) + 17'sd1;
        trial_plus = 1'b1;
      end
      DIR_COL_DN: trial_col = 17'(off_col) - 17'sd1;
      default: begin
        trial_col  = 17'(off_col) + 17'sd1;
        trial_plus = 1'b1;
      end
    endcase
    // The square changes by (old + new) on an upward step and by -(old + new) on a downward step.
    if (q_entry.direction == DIR_ROW_DN || q_entry.direction == DIR_ROW_UP) begin
      trial_pair = 18'(off_row) + 18'(trial_row);
    end else begin
      trial_pair = 18'(off_col) + 18'(trial_col);
    end
    in_range = (trial_row >= -OFF_LIMIT) && (trial_row <= OFF_LIMIT) &&
               (trial_col >= -OFF_LIMIT) && (trial_col <= OFF_LIMIT);
    look_row = start_row + trial_row[GRID_BITS-1:0];
    look_col = start_col + trial_col[GRID_BITS-1:0];
  end

  assign ram_raddr = {look_row, look_col};
  assign ram_waddr = {GRID_BITS'(q_entry.cell_row), GRID_BITS'(q_entry.cell_col)};
  assign ram_wdata = VALUE_BITS'(q_entry.cell_value);

  assign disp_sum = $signed({1'b0, disp_sq}) + 32'(pend_delta);
  assign sum_ext  = {1'b0, sum_sq} + 49'(disp_sq);
  assign out_free = !out_valid || out_ready;

  // Sequencer: a trial step that reads the grid passes through B_LOOKUP; every other operation completes in B_IDLE.
  always_comb begin
    bstate_next      = bstate;
    start_row_next   = start_row;
    start_col_next   = start_col;
    off_row_next     = off_row;
    off_col_next     = off_col;
    disp_sq_next     = disp_sq;
    sum_sq_next      = sum_sq;
    walk_count_next  = walk_count;
    pend_row_next    = pend_row;
    pend_col_next    = pend_col;
    pend_delta_next  = pend_delta;
    pend_thresh_next = pend_thresh;
    q_pop            = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    load_out         = 1'b0;
    moved            = 1'b0;

    unique case (bstate)
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_entry.kind)
            K_WRITE: begin
              ram_we   = 1'b1;
              load_out = 1'b1;
            end
            K_START: begin
              start_row_next = GRID_BITS'(q_entry.cell_row);
              start_col_next = GRID_BITS'(q_entry.cell_col);
              off_row_next   = '0;
              off_col_next   = '0;
              disp_sq_next   = '0;
              load_out       = 1'b1;
            end
            K_STEP: begin
              if (in_range) begin
                ram_re           = 1'b1;
                pend_row_next    = trial_row[15:0];
                pend_col_next    = trial_col[15:0];
                pend_delta_next  = trial_plus ? trial_pair : -trial_pair;
                pend_thresh_next = q_entry.thresh;
                bstate_next      = B_LOOKUP;
              end else begin
                load_out = 1'b1;
              end
            end
            K_FINISH: begin
              sum_sq_next = sum_ext[48] ? '1 : sum_ext[47:0];
              if (walk_count != '1) begin
                walk_count_next = walk_count + 32'd1;
              end
              load_out = 1'b1;
            end
            K_CLEAR: begin
              sum_sq_next     = '0;
              walk_count_next = '0;
              load_out        = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      B_LOOKUP: begin
        // The result slot was free when the step was issued, so it still is.
        if (CMP_W'(pend_thresh) < CMP_W'(ram_rdata)) begin
          off_row_next = pend_row;
          off_col_next = pend_col;
          disp_sq_next = disp_sum[30:0];
          moved        = 1'b1;
        end
        load_out    = 1'b1;
        bstate_next = B_IDLE;
      end
      default: begin
        bstate_next = B_IDLE;
      end
    endcase
  end

  // Result register reports the state after the operation.
  always_comb begin
    pos_row_g      = start_row_next + off_row_next[GRID_BITS-1:0];
    pos_col_g      = start_col_next + off_col_next[GRID_BITS-1:0];
    out_data_next  = out_data;
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next              = 1'b1;
      out_data_next.pos_row       = 8'(pos_row_g);
      out_data_next.pos_col       = 8'(pos_col_g);
      out_data_next.moved         = moved;
      out_data_next.disp_sq       = disp_sq_next;
      out_data_next.total_disp_sq = sum_sq_next;
      out_data_next.walks_done    = walk_count_next;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_lookup_one_cycle: assert property (@(posedge clk) disable iff (rst)
    bstate == B_LOOKUP |=> bstate == B_IDLE)
    else $error("grid lookup lasted more than one cycle");

  a_lookup_slot_free: assert property (@(posedge clk) disable iff (rst)
    bstate == B_LOOKUP |-> !out_valid)
    else $error("result slot occupied while a trial step completes");

  a_disp_matches: assert property (@(posedge clk) disable iff (rst)
    32'(disp_sq) == 32'(32'(off_row) * 32'(off_row) + 32'(off_col) * 32'(off_col)))
    else $error("running squared displacement disagrees with offsets");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    off_row != 16'sh8000 && off_col != 16'sh8000)
    else $error("walk offset beyond its limit");
`endif

endmodule

[src/lattice_walker_metropolis.sv]
// Lattice random walker with Metropolis-style acceptance on a periodic grid.
// Input channel (in_valid/in_ready/in_data) takes one operation word per
// cycle while the queue has room: write a grid cell, start a walk, take a
// trial step, finish the walk or clear the totals. Every word yields exactly
// one result word on the output channel (out_valid/out_ready/out_data) with
// the walker position, the step outcome, the current squared displacement
// and the totals. The cfg channel writes dmax, which scales the acceptance draw.
// Throughput is one word per cycle while the receiver takes results, except
// a trial step, which occupies the back end first for the synchronous grid
// read and then to decide and update the position that the next step
// starts from.
// A two-entry queue decouples the input side from the back end, so input
// keeps flowing while a result waits; when the receiver stalls the result
// register holds and the queue fills, then in_ready drops.
// Synchronous reset clears the walk, totals and queue and sets dmax to its
// maximum. The grid is not cleared: read only cells that were written.
module lattice_walker_metropolis #(
  parameter int GRID_BITS  = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lwm_pkg::lwm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lwm_pkg::lwm_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  import lwm_pkg::*;

  localparam int ADDR_W = 2 * GRID_BITS;

  logic                  q_full;
  logic                  q_push;
  lwm_entry_t            q_in;
  logic                  q_valid;
  logic                  q_pop;
  lwm_entry_t            q_head;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  // Decode and threshold computation.
  lwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // Operations waiting for the back end.
  lwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .valid      (q_valid),
    .pop        (q_pop),
    .head       (q_head)
  );

  // Grid of diffusivities.
  lwm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (1 << ADDR_W)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Walk state, totals and result register.
  lwm_back #(
    .GRID_BITS  (GRID_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
